/* design/crf_pkg.sv */
// Shared types and constants for the RGB LED crossfade unit.
package crf_pkg;

    // Palette and register file geometry
    localparam int PALETTE_DEPTH = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int TIME_W        = 16;
    localparam int POS_W         = 3;

    // Divider: dividend holds an 8 x 16 product plus a rounding term
    localparam int DIV_DVD_W = COLOR_W + 1;
    localparam int DIV_DVS_W = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FADE_DURATION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_0     = 3'd2;

    // Reset values
    localparam logic [TIME_W-1:0]  FADE_RESET    = 16'd500;
    localparam logic [POS_W-1:0]   COUNT_RESET   = 3'd1;
    localparam logic [COLOR_W-1:0] PAL0_RESET    = 24'hFFFFFF;
    localparam logic [CHAN_W-1:0]  BRIGHT_RESET  = 8'd255;

    // Item operations
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_NEXT    = 3'd1,
        OP_PREV    = 3'd2,
        OP_RESTART = 3'd3,
        OP_BRIGHT  = 3'd4
    } t_crf_op;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BLEND_MUL,
        S_BLEND_START,
        S_BLEND_WAIT,
        S_SCALE_MUL,
        S_SCALE_FIX,
        S_DONE
    } t_crf_state;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] level;
    } t_crf_in;

    typedef struct packed {
        logic [7:0] pwm_red;
        logic [7:0] pwm_green;
        logic [7:0] pwm_blue;
        logic [2:0] color_index;
        logic       state_changed;
    } t_crf_out;

endpackage

/* design/rgb_led_crossfade_unit.sv */
// RGB LED crossfade: palette stepping, linear fade and brightness scaling.
// Most items run a multiply and a fix step per channel before the result is registered; a
// tick that advances a fade first spends, on each channel, a multiply, a divider start,
// a 25-step divide and the divider done cycle.
// Throughput: one item at a time; the input reopens in the same cycle as the result is
// registered, and stays closed while an earlier result still stalls.
// Synchronous active-low reset restores register defaults and fade state.
module rgb_led_crossfade_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  crf_pkg::t_crf_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output crf_pkg::t_crf_out                   o_out_data,
    input  logic                                i_cfg_wr_en,
    input  logic [crf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // Byte lane helpers, channel 0 is red in the top byte
    function automatic logic [7:0] chan_of(input logic [23:0] c, input logic [1:0] ch);
        logic [7:0] b;
        unique case (ch)
            2'd0:    b = c[23:16];
            2'd1:    b = c[15:8];
            default: b = c[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [23:0] chan_set(input logic [23:0] c, input logic [1:0] ch,
                                             input logic [7:0] v);
        logic [23:0] r;
        r = c;
        unique case (ch)
            2'd0:    r[23:16] = v;
            2'd1:    r[15:8]  = v;
            default: r[7:0]   = v;
        endcase
        return r;
    endfunction

    // Configuration registers
    logic [crf_pkg::TIME_W-1:0]  r_fade;
    logic [crf_pkg::POS_W-1:0]   r_count;
    logic [crf_pkg::COLOR_W-1:0] r_pal [crf_pkg::PALETTE_DEPTH];

    // Fade state
    crf_pkg::t_crf_state         r_state, n_state;
    logic [1:0]                  r_ch, n_ch;
    logic [crf_pkg::COLOR_W-1:0] r_cur, n_cur;
    logic [crf_pkg::COLOR_W-1:0] r_start, n_start;
    logic [crf_pkg::COLOR_W-1:0] r_tgt, n_tgt;
    logic [crf_pkg::TIME_W-1:0]  r_elapsed, n_elapsed;
    logic [crf_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [crf_pkg::CHAN_W-1:0]  r_bright, n_bright;
    logic                        r_changed, n_changed;
    logic                        r_neg, n_neg;
    logic                        r_out_valid, n_out_valid;

    // Datapath registers
    logic [crf_pkg::COLOR_W-1:0] r_prod, n_prod;
    logic [crf_pkg::COLOR_W-1:0] r_pwm, n_pwm;
    crf_pkg::t_crf_out           r_out, n_out;

    // Shared multiplier and divider signals
    logic [7:0]                          mul_a;
    logic [15:0]                         mul_b;
    logic [23:0]                         mul_p;
    logic                                div_start;
    logic [crf_pkg::DIV_DVD_W-1:0]       div_dividend;
    logic                                div_done;
    logic [crf_pkg::DIV_DVD_W-1:0]       div_quo;

    // Item decode helpers
    logic [crf_pkg::POS_W-1:0]   cnt_eff;
    logic [crf_pkg::POS_W-1:0]   cnt_m1;
    logic [crf_pkg::POS_W-1:0]   pos_sel;
    logic [crf_pkg::COLOR_W-1:0] pal_rd;
    logic [crf_pkg::TIME_W-1:0]  el_inc;
    logic [7:0]                  s_ch, t_ch, q8, blend;
    logic [16:0]                 scale_sum;

    assign mul_p = 24'(mul_a) * 24'(mul_b);

    crf_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_fade),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Register writes: the user must write only while idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade  <= crf_pkg::FADE_RESET;
            r_count <= crf_pkg::COUNT_RESET;
            for (int k = 0; k < crf_pkg::PALETTE_DEPTH; k++) begin
                r_pal[k] <= (k == 0) ? crf_pkg::PAL0_RESET : '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == crf_pkg::REG_FADE_DURATION) begin
                r_fade <= i_cfg_data[crf_pkg::TIME_W-1:0];
            end else if (i_cfg_index == crf_pkg::REG_COLOR_COUNT) begin
                r_count <= i_cfg_data[crf_pkg::POS_W-1:0];
            end else begin
                for (int k = 0; k < crf_pkg::PALETTE_DEPTH; k++) begin
                    if (4'(i_cfg_index) == 4'(k) + 4'(crf_pkg::REG_PALETTE_0)) begin
                        r_pal[k] <= i_cfg_data[crf_pkg::COLOR_W-1:0];
                    end
                end
            end
        end
    end

    // Effective palette size, clamped to one..depth
    always_comb begin
        if (r_count == '0) begin
            cnt_eff = crf_pkg::POS_W'(1);
        end else if (4'(r_count) > 4'(crf_pkg::PALETTE_DEPTH)) begin
            cnt_eff = crf_pkg::POS_W'(crf_pkg::PALETTE_DEPTH);
        end else begin
            cnt_eff = r_count;
        end
        cnt_m1 = cnt_eff - 1'b1;
    end

    // New palette position for colour steps
    always_comb begin
        unique case (i_in_data.operation)
            crf_pkg::OP_NEXT: pos_sel = (r_pos >= cnt_m1) ? '0 : r_pos + 1'b1;
            crf_pkg::OP_PREV: pos_sel = (r_pos == '0) ? cnt_m1 : r_pos - 1'b1;
            default:          pos_sel = '0;
        endcase
        pal_rd = '0;
        for (int k = 0; k < crf_pkg::PALETTE_DEPTH; k++) begin
            if (4'(pos_sel) == 4'(k)) begin
                pal_rd = r_pal[k];
            end
        end
        el_inc = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_cur       = r_cur;
        n_start     = r_start;
        n_tgt       = r_tgt;
        n_elapsed   = r_elapsed;
        n_pos       = r_pos;
        n_bright    = r_bright;
        n_changed   = r_changed;
        n_neg       = r_neg;
        n_prod      = r_prod;
        n_pwm       = r_pwm;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = {1'b0, r_prod};

        s_ch      = chan_of(r_start, r_ch);
        t_ch      = chan_of(r_tgt, r_ch);
        q8        = div_quo[7:0];
        blend     = r_neg ? s_ch - q8 : s_ch + q8;
        scale_sum = 17'(r_prod[15:0]) + 17'(r_prod[15:8]) + 17'd1;

        unique case (r_state)
            crf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_changed = 1'b0;
                    n_ch      = '0;
                    n_state   = crf_pkg::S_SCALE_MUL;
                    unique case (i_in_data.operation)
                        crf_pkg::OP_TICK: begin
                            n_elapsed = el_inc;
                            if (r_cur != r_tgt) begin
                                if (el_inc >= r_fade) begin
                                    n_cur = r_tgt;
                                end else begin
                                    n_state = crf_pkg::S_BLEND_MUL;
                                end
                            end
                        end
                        crf_pkg::OP_NEXT, crf_pkg::OP_PREV, crf_pkg::OP_RESTART: begin
                            n_pos     = pos_sel;
                            n_tgt     = pal_rd;
                            n_start   = r_cur;
                            n_elapsed = '0;
                            n_changed = 1'b1;
                        end
                        crf_pkg::OP_BRIGHT: begin
                            n_bright  = i_in_data.level;
                            n_changed = 1'b1;
                        end
                        default: begin
                            // unused codes leave the state alone
                        end
                    endcase
                end
            end
            crf_pkg::S_BLEND_MUL: begin
                // magnitude of the channel difference times elapsed time
                n_neg   = (t_ch < s_ch);
                mul_a   = (t_ch < s_ch) ? s_ch - t_ch : t_ch - s_ch;
                mul_b   = r_elapsed;
                n_prod  = mul_p;
                n_state = crf_pkg::S_BLEND_START;
            end
            crf_pkg::S_BLEND_START: begin
                // falling channel rounds the quotient up
                div_start    = 1'b1;
                div_dividend = {1'b0, r_prod} +
                               (r_neg ? crf_pkg::DIV_DVD_W'(r_fade) - 1'b1 : '0);
                n_state      = crf_pkg::S_BLEND_WAIT;
            end
            crf_pkg::S_BLEND_WAIT: begin
                if (div_done) begin
                    n_cur = chan_set(r_cur, r_ch, blend);
                    if (r_ch == 2'd2) begin
                        n_ch    = '0;
                        n_state = crf_pkg::S_SCALE_MUL;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = crf_pkg::S_BLEND_MUL;
                    end
                end
            end
            crf_pkg::S_SCALE_MUL: begin
                mul_a   = chan_of(r_cur, r_ch);
                mul_b   = {8'd0, r_bright};
                n_prod  = mul_p;
                n_state = crf_pkg::S_SCALE_FIX;
            end
            crf_pkg::S_SCALE_FIX: begin
                // exact floor(x / 255) for x up to 255 * 255
                n_pwm = {r_pwm[15:0], scale_sum[15:8]};
                if (r_ch == 2'd2) begin
                    n_state = crf_pkg::S_DONE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = crf_pkg::S_SCALE_MUL;
                end
            end
            crf_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.pwm_red       = r_pwm[23:16];
                    n_out.pwm_green     = r_pwm[15:8];
                    n_out.pwm_blue      = r_pwm[7:0];
                    n_out.color_index   = r_pos;
                    n_out.state_changed = r_changed;
                    n_out_valid         = 1'b1;
                    n_state             = crf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = crf_pkg::S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= crf_pkg::S_IDLE;
            r_ch        <= '0;
            r_cur       <= '0;
            r_start     <= '0;
            r_tgt       <= '0;
            r_elapsed   <= '0;
            r_pos       <= '0;
            r_bright    <= crf_pkg::BRIGHT_RESET;
            r_changed   <= 1'b0;
            r_neg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_cur       <= n_cur;
            r_start     <= n_start;
            r_tgt       <= n_tgt;
            r_elapsed   <= n_elapsed;
            r_pos       <= n_pos;
            r_bright    <= n_bright;
            r_changed   <= n_changed;
            r_neg       <= n_neg;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pwm  <= n_pwm;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != crf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/crf_divider.sv */
// Restoring divider, one quotient bit per cycle.
module crf_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [crf_pkg::DIV_DVD_W-1:0]      i_dividend,
    input  logic [crf_pkg::DIV_DVS_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [crf_pkg::DIV_DVD_W-1:0]      o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [crf_pkg::DIV_CNT_W-1:0]      r_cnt;
    logic [crf_pkg::DIV_DVD_W-1:0]      r_quo;
    logic [crf_pkg::DIV_DVS_W-1:0]      r_rem;
    logic [crf_pkg::DIV_DVS_W-1:0]      r_dvs;

    logic [crf_pkg::DIV_DVS_W:0]        trial;
    logic [crf_pkg::DIV_DVS_W:0]        diff;
    logic                               fits;
    logic [crf_pkg::DIV_DVS_W-1:0]      n_rem;
    logic [crf_pkg::DIV_DVD_W-1:0]      n_quo;

    // One shift-and-subtract step
    always_comb begin
        trial = {r_rem, r_quo[crf_pkg::DIV_DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? diff[crf_pkg::DIV_DVS_W-1:0] : trial[crf_pkg::DIV_DVS_W-1:0];
        n_quo = {r_quo[crf_pkg::DIV_DVD_W-2:0], fits};
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= crf_pkg::DIV_CNT_W'(crf_pkg::DIV_DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == crf_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* design/crf_checker.sv */
// Port-level checks for the crossfade unit, bound to the top level.
module crf_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_stall,
    input  logic              o_out_valid,
    input  logic              i_out_stall,
    input  crf_pkg::t_crf_out o_out_data
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // One item in flight: a transfer closes the input
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a transfer");

    // Reset leaves the block open and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

    // Targeted entry stays within the palette
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.color_index) < crf_pkg::PALETTE_DEPTH)
        else $error("colour index out of range");

endmodule

bind rgb_led_crossfade_unit crf_checker u_crf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
